// ===== rtl/core/wwgp_pkg.sv =====
// ----------------------------------------------------------------------------
// wwgp_pkg
// Shared types, codes and constants of the word wrap glyph placer.
// ----------------------------------------------------------------------------
package wwgp_pkg;

  localparam int LINE_CHARS_DEF  = 64;
  localparam int TABLE_ENTRIES   = 128;
  localparam int CODE_W          = 7;
  localparam int ADV_W           = 8;
  localparam int COORD_W         = 16;
  localparam int LH_W            = 8;
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH = 2;

  localparam logic [CODE_W-1:0]  CH_SPACE     = 7'd32;
  localparam logic [CODE_W-1:0]  CH_NEWLINE   = 7'd10;
  localparam logic [COORD_W-1:0] WRAP_RESET   = 16'd320;
  localparam logic [LH_W-1:0]    LH_RESET     = 8'd11;

  typedef enum logic [1:0] {
    FUNC_TEXT = 2'd0,
    FUNC_END  = 2'd1,
    FUNC_LOAD = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_WRAP_WIDTH = 2'd2,
    REG_ROW_PITCH  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    CMD_GLYPH,
    CMD_SPACE,
    CMD_NEWLINE,
    CMD_END,
    CMD_LOAD
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PEND_WT,
    ST_APPEND,
    ST_DRAW_RD,
    ST_DRAW_WT,
    ST_DRAW_EMIT,
    ST_POST,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    POST_BREAK,
    POST_NEWLINE,
    POST_END
  } post_e;

  typedef struct packed {
    cmd_e              kind;
    logic [CODE_W-1:0] code;
    logic [ADV_W-1:0]  width;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] wrap_width;
    logic [LH_W-1:0]    row_pitch;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CODE_W-1:0]  code;
    logic               last;
  } glyph_t;

  localparam int CMD_W   = $bits(cmd_t);
  localparam int GLYPH_W = $bits(glyph_t);

endpackage

// ===== rtl/core/wwgp_ram.sv =====
// ----------------------------------------------------------------------------
// wwgp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module wwgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/wwgp_fifo.sv =====
// ----------------------------------------------------------------------------
// wwgp_fifo
// Small register FIFO with full and empty flags.
// ----------------------------------------------------------------------------
module wwgp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr_fire, rd_fire;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign wr_fire   = wr_en_i && !full_o;
  assign rd_fire   = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_fire ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_fire ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(wr_fire) - CW'(rd_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/core/wwgp_front.sv =====
// ----------------------------------------------------------------------------
// wwgp_front
// Accepts input requests, classifies them and queues commands for the back.
// ----------------------------------------------------------------------------
module wwgp_front
  import wwgp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        func_i,
  input  logic [CODE_W-1:0] char_code_i,
  input  logic [ADV_W-1:0]  width_value_i,
  output cmd_t              cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i
);

  cmd_t             cmd;
  logic             keep;
  logic             q_empty;
  logic [CMD_W-1:0] q_rdata;

  always_comb begin
    cmd.code  = char_code_i;
    cmd.width = width_value_i;
    cmd.kind  = CMD_GLYPH;
    keep      = 1'b1;
    unique case (func_i)
      FUNC_TEXT: begin
        if (char_code_i == CH_NEWLINE) begin
          cmd.kind = CMD_NEWLINE;
        end else if (char_code_i == CH_SPACE) begin
          cmd.kind = CMD_SPACE;
        end else begin
          cmd.kind = CMD_GLYPH;
        end
      end
      FUNC_END:  cmd.kind = CMD_END;
      FUNC_LOAD: cmd.kind = CMD_LOAD;
      FUNC_NOP:  keep = 1'b0;
    endcase
  end

  wwgp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push && keep),
    .wr_data_i (cmd),
    .full_o    (full),
    .rd_en_i   (cmd_pop_i),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  assign cmd_o       = cmd_t'(q_rdata);
  assign cmd_valid_o = !q_empty;

endmodule

// ===== rtl/core/wwgp_back.sv =====
// ----------------------------------------------------------------------------
// wwgp_back
// Line sequencer: buffers the line, checks breaks, replays and draws glyphs.
// ----------------------------------------------------------------------------
module wwgp_back
  import wwgp_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               pen_load_i,
  input  logic [COORD_W-1:0] pen_val_i,
  input  cmd_t               cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  logic               pop,
  output glyph_t             glyph_o
);

  localparam int PW = $clog2(LINE_CHARS);
  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam int SW = CW + 1;
  localparam int TW = $clog2(TABLE_ENTRIES);

  state_e             state_q, state_d, done_st;
  post_e              post_q, post_d;
  cmd_t               cur_q, cur_d;
  logic [PW-1:0]      base_q, base_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      pend_q, pend_d;
  logic [PW-1:0]      space_q, space_d;
  logic [COORD_W-1:0] sum_q, sum_d;
  logic [COORD_W-1:0] pen_y_q, pen_y_d;
  logic [COORD_W-1:0] x_q, x_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      len_q, len_d;
  logic [CODE_W-1:0]  work_code_q, work_code_d;
  logic               from_cur_q, from_cur_d;
  glyph_t             hold_q, hold_d;
  logic               hold_valid_q, hold_valid_d;

  logic               lb_we, lb_re;
  logic [PW-1:0]      lb_waddr, lb_raddr;
  logic [CODE_W-1:0]  lb_wdata, lb_rdata;
  logic               wt_we, wt_re;
  logic [TW-1:0]      wt_waddr, wt_raddr;
  logic [ADV_W-1:0]   wt_wdata, wt_rdata;

  logic               of_push, of_full, of_empty;
  glyph_t             of_wdata;
  logic [GLYPH_W-1:0] of_rdata;

  logic               brk, emit_stall;
  logic [CW-1:0]      cut;

  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] b,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(off);
    if (s >= SW'(LINE_CHARS)) begin
      s = s - SW'(LINE_CHARS);
    end
    return s[PW-1:0];
  endfunction

  assign cut = (space_q != '0) ? CW'(space_q) : count_q;
  assign brk = (count_q != '0) &&
               ((sum_q > cfg_i.wrap_width) ||
                ((count_q == CW'(LINE_CHARS)) && (cur_q.kind != CMD_NEWLINE)));
  assign emit_stall = (work_code_q != CH_SPACE) && hold_valid_q && of_full;
  assign done_st    = hold_valid_q ? ST_FINISH : ST_IDLE;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind != CMD_LOAD)) begin
          state_d = (cmd_i.kind == CMD_END) ? ST_DRAW_RD : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (brk) begin
          state_d = ST_DRAW_RD;
        end else if (pend_q != '0) begin
          state_d = ST_PEND_WT;
        end else if (cur_q.kind == CMD_NEWLINE) begin
          state_d = ST_DRAW_RD;
        end else if ((cur_q.kind == CMD_SPACE) && (count_q == '0)) begin
          state_d = done_st;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_PEND_WT: begin
        state_d = ((lb_rdata == CH_SPACE) && (count_q == '0)) ? ST_CHECK : ST_APPEND;
      end
      ST_APPEND:    state_d = from_cur_q ? done_st : ST_CHECK;
      ST_DRAW_RD:   state_d = (idx_q == len_q) ? ST_POST : ST_DRAW_WT;
      ST_DRAW_WT:   state_d = ST_DRAW_EMIT;
      ST_DRAW_EMIT: state_d = emit_stall ? ST_DRAW_EMIT : ST_DRAW_RD;
      ST_POST:      state_d = (post_q == POST_BREAK) ? ST_CHECK : done_st;
      ST_FINISH:    state_d = of_full ? ST_FINISH : ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    post_d       = post_q;
    cur_d        = cur_q;
    base_d       = base_q;
    count_d      = count_q;
    pend_d       = pend_q;
    space_d      = space_q;
    sum_d        = sum_q;
    pen_y_d      = pen_y_q;
    x_d          = x_q;
    idx_d        = idx_q;
    len_d        = len_q;
    work_code_d  = work_code_q;
    from_cur_d   = from_cur_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    cmd_pop_o    = 1'b0;
    lb_we        = 1'b0;
    lb_waddr     = ptr_add(base_q, count_q);
    lb_wdata     = cur_q.code;
    lb_re        = 1'b0;
    lb_raddr     = ptr_add(base_q, count_q);
    wt_we        = 1'b0;
    wt_waddr     = cmd_i.code;
    wt_wdata     = cmd_i.width;
    wt_re        = 1'b0;
    wt_raddr     = cur_q.code;
    of_push      = 1'b0;
    of_wdata     = hold_q;
    of_wdata.last = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          if (cmd_i.kind == CMD_LOAD) begin
            wt_we = 1'b1;
          end
          if (cmd_i.kind == CMD_END) begin
            idx_d  = '0;
            len_d  = count_q;
            x_d    = cfg_i.origin_x;
            post_d = POST_END;
          end
        end
      end
      ST_CHECK: begin
        if (brk) begin
          idx_d  = '0;
          len_d  = cut;
          x_d    = cfg_i.origin_x;
          post_d = POST_BREAK;
        end else if (pend_q != '0) begin
          lb_re = 1'b1;
        end else if (cur_q.kind == CMD_NEWLINE) begin
          idx_d  = '0;
          len_d  = count_q;
          x_d    = cfg_i.origin_x;
          post_d = POST_NEWLINE;
        end else if (!((cur_q.kind == CMD_SPACE) && (count_q == '0))) begin
          lb_we       = 1'b1;
          wt_re       = 1'b1;
          work_code_d = cur_q.code;
          from_cur_d  = 1'b1;
        end
      end
      ST_PEND_WT: begin
        if ((lb_rdata == CH_SPACE) && (count_q == '0)) begin
          base_d = ptr_add(base_q, CW'(1));
          pend_d = pend_q - 1'b1;
        end else begin
          wt_re       = 1'b1;
          wt_raddr    = lb_rdata;
          work_code_d = lb_rdata;
          from_cur_d  = 1'b0;
        end
      end
      ST_APPEND: begin
        sum_d   = sum_q + 16'(wt_rdata);
        count_d = count_q + 1'b1;
        if (work_code_q == CH_SPACE) begin
          space_d = count_q[PW-1:0];
        end
        if (!from_cur_q) begin
          pend_d = pend_q - 1'b1;
        end
      end
      ST_DRAW_RD: begin
        if (idx_q != len_q) begin
          lb_re    = 1'b1;
          lb_raddr = ptr_add(base_q, idx_q);
        end
      end
      ST_DRAW_WT: begin
        wt_re       = 1'b1;
        wt_raddr    = lb_rdata;
        work_code_d = lb_rdata;
      end
      ST_DRAW_EMIT: begin
        if (!emit_stall) begin
          x_d   = x_q + 16'(wt_rdata);
          idx_d = idx_q + 1'b1;
          if (work_code_q != CH_SPACE) begin
            of_push      = hold_valid_q;
            hold_d.x     = x_q;
            hold_d.y     = pen_y_q;
            hold_d.code  = work_code_q;
            hold_d.last  = 1'b0;
            hold_valid_d = 1'b1;
          end
        end
      end
      ST_POST: begin
        count_d = '0;
        sum_d   = '0;
        space_d = '0;
        unique case (post_q)
          POST_BREAK: begin
            base_d  = ptr_add(base_q, len_q);
            pend_d  = pend_q + count_q - len_q;
            pen_y_d = pen_y_q + 16'(cfg_i.row_pitch);
          end
          POST_NEWLINE: pen_y_d = pen_y_q + 16'(cfg_i.row_pitch);
          POST_END:     pen_y_d = cfg_i.origin_y;
          default:      pen_y_d = pen_y_q;
        endcase
      end
      ST_FINISH: begin
        if (!of_full) begin
          of_push       = 1'b1;
          of_wdata.last = 1'b1;
          hold_valid_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (pen_load_i) begin
      pen_y_d = pen_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      post_q       <= POST_END;
      from_cur_q   <= 1'b0;
      base_q       <= '0;
      count_q      <= '0;
      pend_q       <= '0;
      space_q      <= '0;
      sum_q        <= '0;
      pen_y_q      <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      post_q       <= post_d;
      from_cur_q   <= from_cur_d;
      base_q       <= base_d;
      count_q      <= count_d;
      pend_q       <= pend_d;
      space_q      <= space_d;
      sum_q        <= sum_d;
      pen_y_q      <= pen_y_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    x_q         <= x_d;
    idx_q       <= idx_d;
    len_q       <= len_d;
    work_code_q <= work_code_d;
    hold_q      <= hold_d;
  end

  wwgp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (LINE_CHARS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (lb_waddr),
    .wdata_i (lb_wdata),
    .re_i    (lb_re),
    .raddr_i (lb_raddr),
    .rdata_o (lb_rdata)
  );

  wwgp_ram #(
    .WIDTH (ADV_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_width_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wt_waddr),
    .wdata_i (wt_wdata),
    .re_i    (wt_re),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rdata)
  );

  wwgp_fifo #(
    .WIDTH (GLYPH_W),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (of_push),
    .wr_data_i (of_wdata),
    .full_o    (of_full),
    .rd_en_i   (pop),
    .rd_data_o (of_rdata),
    .empty_o   (of_empty)
  );

  assign empty   = of_empty;
  assign glyph_o = glyph_t'(of_rdata);

endmodule

// ===== rtl/core/word_wrap_glyph_placer_unit.sv =====
// Sequencing: a plain character passes the check and append states, a width load
// is written from idle. A character of a line drawn on a break, newline or end of
// text passes draw read, wait and emit, spaces too; one replayed after a break
// passes pending wait and append; every RAM read is registered. The last result of
// a newline or end of text is held and enters the output queue from the finish state.
// Reset: line empty, pen y at origin y, state and configuration registers to defaults; RAMs not cleared.
// ----------------------------------------------------------------------------
// word_wrap_glyph_placer_unit
// Greedy word wrap glyph placer for a proportional font, top level.
// ----------------------------------------------------------------------------
module word_wrap_glyph_placer_unit
  import wwgp_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         func_i,
  input  logic [CODE_W-1:0]  char_code_i,
  input  logic [ADV_W-1:0]   width_value_i,
  output logic               empty,
  input  logic               pop,
  output logic [COORD_W-1:0] glyph_x_o,
  output logic [COORD_W-1:0] glyph_y_o,
  output logic [CODE_W-1:0]  glyph_code_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [COORD_W-1:0] cfg_wdata_i
);

  cfg_t   cfg_q, cfg_d;
  cmd_t   cmd;
  logic   cmd_valid, cmd_pop;
  logic   pen_load;
  glyph_t glyph;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ORIGIN_X:   cfg_d.origin_x   = cfg_wdata_i;
        REG_ORIGIN_Y:   cfg_d.origin_y   = cfg_wdata_i;
        REG_WRAP_WIDTH: cfg_d.wrap_width = cfg_wdata_i;
        REG_ROW_PITCH:  cfg_d.row_pitch  = cfg_wdata_i[LH_W-1:0];
      endcase
    end
  end

  assign pen_load = cfg_we_i && (cfg_addr_i == REG_ORIGIN_Y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
      cfg_q.wrap_width <= WRAP_RESET;
      cfg_q.row_pitch  <= LH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wwgp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .width_value_i (width_value_i),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop)
  );

  wwgp_back #(
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pen_load_i  (pen_load),
    .pen_val_i   (cfg_wdata_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .glyph_o     (glyph)
  );

  assign glyph_x_o    = glyph.x;
  assign glyph_y_o    = glyph.y;
  assign glyph_code_o = glyph.code;
  assign last_o       = glyph.last;

endmodule
